/* sv/fdtd_pkg.sv */
// Shared constants, types and arithmetic helpers for the 1D field update block.
package fdtd_pkg;

  localparam int GRID_MAX   = 256;
  localparam int DEPTH      = GRID_MAX + 1;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int DATA_W     = 32;
  localparam int NODES_W    = 9;
  localparam int SRC_W      = 8;
  localparam int IDX_W      = 8;
  localparam int ECOEF_W    = 31;
  localparam int HCOEF_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int FRAC_W     = 16;
  localparam int DIFF_W     = DATA_W + 1;
  localparam int HPROD_W    = DIFF_W + HCOEF_W + 1;
  localparam int EPROD_W    = DIFF_W + ECOEF_W + 1;
  localparam int PROD_W     = EPROD_W + 1;
  localparam int MIN_NODES  = 2;

  localparam logic [NODES_W-1:0] ACTIVE_RST = NODES_W'(200);
  localparam logic [SRC_W-1:0]   SOURCE_RST = SRC_W'(50);
  localparam logic [ECOEF_W-1:0] ECOEF_RST  = ECOEF_W'(24707072);
  localparam logic [HCOEF_W-1:0] HCOEF_RST  = HCOEF_W'(174);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_FINISH
  } fdtd_state_t;

  typedef enum logic {
    OP_STEP = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic {
    KIND_STEP = 1'b0,
    KIND_READ = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_NODES = 2'd0,
    REG_SOURCE_NODE  = 2'd1,
    REG_E_COEFF      = 2'd2,
    REG_H_COEFF      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  n;
    logic [SRC_W-1:0]   src;
    logic [ECOEF_W-1:0] e_coeff;
    logic [HCOEF_W-1:0] h_coeff;
  } cfg_t;

  typedef struct packed {
    logic              clr_en;
    logic              take_item;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic              slot_valid;
    logic              node_valid;
    logic [ADDR_W-1:0] node_idx;
    logic              first;
    logic              ghost;
    logic              src_hit;
    logic              load_out;
    kind_t             out_kind;
    logic              out_zero;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
  } dp_stat_t;

  // round half up from Q.32 to Q16.16, then saturate to 32 bits
  function automatic logic signed [DATA_W-1:0] scale_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0]        t;
    logic signed [PROD_W-FRAC_W:0] q;
    logic                          fits;
    t = (PROD_W+1)'(p) + (PROD_W+1)'(1 << (FRAC_W - 1));
    q = t[PROD_W:FRAC_W];
    fits = (&q[PROD_W-FRAC_W:DATA_W-1]) || !(|q[PROD_W-FRAC_W:DATA_W-1]);
    if (fits) begin
      return q[DATA_W-1:0];
    end else if (q[PROD_W-FRAC_W]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] add_sat(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] == s[DATA_W-1]) begin
      return s[DATA_W-1:0];
    end else if (s[DATA_W]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

/* sv/fdtd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fdtd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 257
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/fdtd_regs.sv */
// Configuration register file with node count clamping.
module fdtd_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fdtd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fdtd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output fdtd_pkg::cfg_t                   cfg
);
  import fdtd_pkg::*;

  logic [NODES_W-1:0] active_r;
  logic [SRC_W-1:0]   source_r;
  logic [ECOEF_W-1:0] e_coeff_r;
  logic [HCOEF_W-1:0] h_coeff_r;
  logic               wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= ACTIVE_RST;
      source_r  <= SOURCE_RST;
      e_coeff_r <= ECOEF_RST;
      h_coeff_r <= HCOEF_RST;
    end else if (wr) begin
      case (reg_idx_t'(cfg_index))
        REG_ACTIVE_NODES: active_r  <= cfg_data[NODES_W-1:0];
        REG_SOURCE_NODE:  source_r  <= cfg_data[SRC_W-1:0];
        REG_E_COEFF:      e_coeff_r <= cfg_data[ECOEF_W-1:0];
        REG_H_COEFF:      h_coeff_r <= cfg_data[HCOEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(active_r) > 32'(GRID_MAX)) begin
      cfg.n = ADDR_W'(GRID_MAX);
    end else if (32'(active_r) < 32'(MIN_NODES)) begin
      cfg.n = ADDR_W'(MIN_NODES);
    end else begin
      cfg.n = ADDR_W'(active_r);
    end
    cfg.src     = source_r;
    cfg.e_coeff = e_coeff_r;
    cfg.h_coeff = h_coeff_r;
  end

endmodule

/* sv/fdtd_dp.sv */
// Field datapath: grid memories, update pipeline and result registers.
module fdtd_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fdtd_pkg::dp_cmd_t                  cmd,
  input  fdtd_pkg::cfg_t                     cfg,
  input  logic signed [fdtd_pkg::DATA_W-1:0] in_source_sample,
  output fdtd_pkg::dp_stat_t                 stat,
  output logic                               out_result_kind,
  output logic signed [fdtd_pkg::DATA_W-1:0] out_e_value,
  output logic signed [fdtd_pkg::DATA_W-1:0] out_h_value
);
  import fdtd_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] idx;
    logic              first;
    logic              ghost;
    logic              src_hit;
  } tag_t;

  logic signed [DATA_W-1:0] e_rd, h_rd;
  logic                     e_we, h_we;
  logic [ADDR_W-1:0]        e_waddr, h_waddr;
  logic signed [DATA_W-1:0] e_wdata, h_wdata;

  logic slot_v_r, node_v_r, v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r;
  tag_t tag0_r, tag1_r, tag2_r, tag3_r, tag4_r, tag5_r, tag6_r, tag7_r, tag8_r, tag9_r;

  logic signed [DATA_W-1:0]  sample_r;
  logic signed [DATA_W-1:0]  e_d_r, h_d_r, h_d2_r;
  logic signed [DIFF_W-1:0]  de1_r, dh5_r;
  logic signed [DATA_W-1:0]  ea1_r, eb1_r, ho1_r, hcp1_r;
  logic signed [HPROD_W-1:0] ph2_r;
  logic signed [DATA_W-1:0]  ea2_r, eb2_r, ho2_r, hcp2_r;
  logic signed [DATA_W-1:0]  sh3_r, ea3_r, eb3_r, ho3_r, hcp3_r;
  logic signed [DATA_W-1:0]  hn4_r, ea4_r, eb4_r, hn_last_r;
  logic signed [DATA_W-1:0]  ea5_r, eb5_r;
  logic signed [EPROD_W-1:0] pe6_r;
  logic signed [DATA_W-1:0]  ea6_r, eb6_r;
  logic signed [DATA_W-1:0]  se7_r, ea7_r, eb7_r;
  logic signed [DATA_W-1:0]  en8_r, ef9_r;
  logic                      kind_r;
  logic signed [DATA_W-1:0]  out_e_r, out_h_r;

  fdtd_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_e_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .re    (cmd.rd_en),
    .raddr (cmd.addr),
    .rdata (e_rd)
  );

  fdtd_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_h_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .re    (cmd.rd_en),
    .raddr (cmd.addr),
    .rdata (h_rd)
  );

  always_comb begin
    h_we    = cmd.clr_en || v4_r;
    h_waddr = cmd.clr_en ? cmd.addr : tag4_r.idx;
    h_wdata = cmd.clr_en ? '0 : hn4_r;
    e_we    = cmd.clr_en || v9_r;
    e_waddr = cmd.clr_en ? cmd.addr : tag9_r.idx;
    e_wdata = cmd.clr_en ? '0 : ef9_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_v_r <= 1'b0;
      node_v_r <= 1'b0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      v4_r     <= 1'b0;
      v5_r     <= 1'b0;
      v6_r     <= 1'b0;
      v7_r     <= 1'b0;
      v8_r     <= 1'b0;
      v9_r     <= 1'b0;
    end else begin
      slot_v_r <= cmd.slot_valid;
      node_v_r <= cmd.slot_valid && cmd.node_valid;
      v1_r     <= node_v_r;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      v4_r     <= v3_r;
      v5_r     <= v4_r;
      v6_r     <= v5_r;
      v7_r     <= v6_r;
      v8_r     <= v7_r;
      v9_r     <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      sample_r <= in_source_sample;
    end
    tag0_r.idx     <= cmd.node_idx;
    tag0_r.first   <= cmd.first;
    tag0_r.ghost   <= cmd.ghost;
    tag0_r.src_hit <= cmd.src_hit;
    if (slot_v_r) begin
      e_d_r  <= e_rd;
      h_d_r  <= h_rd;
      h_d2_r <= h_d_r;
    end

    tag1_r <= tag0_r;
    de1_r  <= {e_rd[DATA_W-1], e_rd} - {e_d_r[DATA_W-1], e_d_r};
    ea1_r  <= e_d_r;
    eb1_r  <= e_rd;
    ho1_r  <= h_d_r;
    hcp1_r <= h_d2_r;

    tag2_r <= tag1_r;
    ph2_r  <= de1_r * $signed({1'b0, cfg.h_coeff});
    ea2_r  <= ea1_r;
    eb2_r  <= eb1_r;
    ho2_r  <= ho1_r;
    hcp2_r <= hcp1_r;

    tag3_r <= tag2_r;
    sh3_r  <= scale_sat(PROD_W'(ph2_r));
    ea3_r  <= ea2_r;
    eb3_r  <= eb2_r;
    ho3_r  <= ho2_r;
    hcp3_r <= hcp2_r;

    tag4_r <= tag3_r;
    hn4_r  <= tag3_r.ghost ? hcp3_r : add_sat(ho3_r, sh3_r);
    ea4_r  <= ea3_r;
    eb4_r  <= eb3_r;
    if (v4_r) begin
      hn_last_r <= hn4_r;
    end

    tag5_r <= tag4_r;
    dh5_r  <= {hn4_r[DATA_W-1], hn4_r} - {hn_last_r[DATA_W-1], hn_last_r};
    ea5_r  <= ea4_r;
    eb5_r  <= eb4_r;

    tag6_r <= tag5_r;
    pe6_r  <= dh5_r * $signed({1'b0, cfg.e_coeff});
    ea6_r  <= ea5_r;
    eb6_r  <= eb5_r;

    tag7_r <= tag6_r;
    se7_r  <= scale_sat(PROD_W'(pe6_r));
    ea7_r  <= ea6_r;
    eb7_r  <= eb6_r;

    tag8_r <= tag7_r;
    en8_r  <= tag7_r.first ? eb7_r : add_sat(ea7_r, se7_r);

    tag9_r <= tag8_r;
    ef9_r  <= tag8_r.src_hit ? add_sat(en8_r, sample_r) : en8_r;

    if (cmd.load_out) begin
      kind_r  <= cmd.out_kind;
      out_e_r <= cmd.out_zero ? '0 : e_rd;
      out_h_r <= cmd.out_zero ? '0 : h_rd;
    end
  end

  assign stat.busy = slot_v_r || node_v_r || v1_r || v2_r || v3_r || v4_r
                     || v5_r || v6_r || v7_r || v8_r || v9_r;

  assign out_result_kind = kind_r;
  assign out_e_value     = out_e_r;
  assign out_h_value     = out_h_r;

endmodule

/* sv/fdtd_ctrl.sv */
// Controller: clearing pass, sweep sequencing, reads and result handshake.
module fdtd_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [fdtd_pkg::IDX_W-1:0]    in_node_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  input  fdtd_pkg::cfg_t                cfg,
  input  fdtd_pkg::dp_stat_t            stat,
  output fdtd_pkg::dp_cmd_t             cmd
);
  import fdtd_pkg::*;

  fdtd_state_t       state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] n_r, n_nxt;
  logic [SRC_W-1:0]  src_r, src_nxt;
  op_t               op_r, op_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              in_acc;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    src_r   <= src_nxt;
    op_r    <= op_nxt;
    rd_ok_r <= rd_ok_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    src_nxt       = src_r;
    op_nxt        = op_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.out_kind  = KIND_STEP;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        cmd.addr   = cnt_r;
        if (cnt_r == ADDR_W'(GRID_MAX)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          cmd.take_item = 1'b1;
          op_nxt        = op_t'(in_operation);
          if (op_t'(in_operation) == OP_READ) begin
            rd_ok_nxt   = (32'(in_node_index) <= 32'(GRID_MAX));
            cmd.rd_en   = rd_ok_nxt;
            cmd.addr    = ADDR_W'(in_node_index);
            state_nxt   = ST_FINISH;
          end else begin
            n_nxt     = cfg.n;
            src_nxt   = cfg.src;
            cnt_nxt   = '0;
            state_nxt = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        cmd.slot_valid = 1'b1;
        cmd.rd_en      = (cnt_r <= n_r);
        cmd.addr       = cnt_r;
        cmd.node_valid = (cnt_r != '0);
        cmd.node_idx   = cnt_r - 1'b1;
        cmd.first      = (cnt_r == ADDR_W'(1));
        cmd.ghost      = (cnt_r == n_r + 1'b1);
        cmd.src_hit    = cmd.node_valid && (32'(cmd.node_idx) == 32'(src_r));
        if (cmd.ghost) begin
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!stat.busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          cmd.out_kind  = (op_r == OP_READ) ? KIND_READ : KIND_STEP;
          cmd.out_zero  = !((op_r == OP_READ) && rd_ok_r);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> (cnt_r <= n_r + 1'b1))
    else $error("sweep slot past ghost node");

  a_clear_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (cnt_r <= ADDR_W'(GRID_MAX)))
    else $error("clear pass past last entry");

  a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) |-> !stat.busy)
    else $error("result issued with update pipeline busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while held");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (op_t'(in_operation) == OP_STEP)) |=> (state_r == ST_SWEEP) && (cnt_r == '0))
    else $error("step item did not start a sweep");
`endif

endmodule

/* sv/fdtd_1d_field_update.sv */
// Top level of the 1D leapfrog electric and magnetic field update block.
// After reset the block clears both field memories and accepts no item in that
// time; configuration writes are taken throughout. A read item goes from idle to
// the finish state, where its result is loaded once no held result is stalled.
// A step item sweeps the grid one node per cycle through the single read port of
// each field memory, followed by an 11-stage update pipeline, and its result is
// loaded once the pipeline has drained. One item is in work at a time; a held
// result does not block acceptance of the next item.
module fdtd_1d_field_update (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_operation,
  input  logic [fdtd_pkg::IDX_W-1:0]         in_node_index,
  input  logic signed [fdtd_pkg::DATA_W-1:0] in_source_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_result_kind,
  output logic signed [fdtd_pkg::DATA_W-1:0] out_e_value,
  output logic signed [fdtd_pkg::DATA_W-1:0] out_h_value,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fdtd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fdtd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import fdtd_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  fdtd_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fdtd_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_node_index (in_node_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cfg           (cfg),
    .stat          (stat),
    .cmd           (cmd)
  );

  fdtd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg              (cfg),
    .in_source_sample (in_source_sample),
    .stat             (stat),
    .out_result_kind  (out_result_kind),
    .out_e_value      (out_e_value),
    .out_h_value      (out_h_value)
  );

endmodule

/* bench/tb.sv */
// Testbench for fdtd_1d_field_update: shadow E/H grids predict and check every result item.
`timescale 1ns / 100ps
module tb;
  import fdtd_pkg::*;

  typedef struct {
    kind_t                    kind;
    logic signed [DATA_W-1:0] e_val;
    logic signed [DATA_W-1:0] h_val;
  } node_fields_t;

  class yee_shadow;
    logic [NODES_W-1:0]       active_nodes;
    logic [SRC_W-1:0]         source_node;
    logic [ECOEF_W-1:0]       e_coeff;
    logic [HCOEF_W-1:0]       h_coeff;
    logic signed [DATA_W-1:0] e_grid [0:GRID_MAX];
    logic signed [DATA_W-1:0] h_grid [0:GRID_MAX];
    node_fields_t             awaited [$];
    int                       errors;
    int                       steps;
    int                       reads;
    int                       reg_writes;

    function new();
      active_nodes = ACTIVE_RST;
      source_node  = SOURCE_RST;
      e_coeff      = ECOEF_RST;
      h_coeff      = HCOEF_RST;
      foreach (e_grid[i]) begin
        e_grid[i] = '0;
        h_grid[i] = '0;
      end
    endfunction

    function int effective_nodes();
      int n;
      n = int'(active_nodes);
      if (n < MIN_NODES) n = MIN_NODES;
      if (n > GRID_MAX) n = GRID_MAX;
      return n;
    endfunction

    function logic signed [DATA_W-1:0] clamp32(logic signed [95:0] v);
      if (v > 96'sd2147483647) return {1'b0, {31{1'b1}}};
      if (v < -96'sd2147483648) return {1'b1, 31'b0};
      return v[31:0];
    endfunction

    // (hi - lo) * coef in Q.32, round half up to Q16.16, clamp
    function logic signed [DATA_W-1:0] scaled_delta(logic signed [DATA_W-1:0] hi,
                                                    logic signed [DATA_W-1:0] lo,
                                                    logic [31:0] coef);
      logic signed [95:0] a;
      logic signed [95:0] b;
      logic signed [95:0] c;
      a = 96'(hi);
      b = 96'(lo);
      c = {64'd0, coef};
      return clamp32(((a - b) * c + 96'sd32768) >>> 16);
    endfunction

    function logic signed [DATA_W-1:0] sum_clamped(logic signed [DATA_W-1:0] x,
                                                   logic signed [DATA_W-1:0] y);
      logic signed [95:0] a;
      logic signed [95:0] b;
      a = 96'(x);
      b = 96'(y);
      return clamp32(a + b);
    endfunction

    function void write_reg(reg_idx_t r, logic [CFG_DATA_W-1:0] d);
      reg_writes++;
      case (r)
        REG_ACTIVE_NODES: active_nodes = d[NODES_W-1:0];
        REG_SOURCE_NODE:  source_node  = d[SRC_W-1:0];
        REG_E_COEFF:      e_coeff      = d[ECOEF_W-1:0];
        REG_H_COEFF:      h_coeff      = d[HCOEF_W-1:0];
        default: ;
      endcase
    endfunction

    function void accept(op_t op, logic [IDX_W-1:0] idx, logic signed [DATA_W-1:0] smp);
      node_fields_t f;
      int           n;
      f.kind  = KIND_STEP;
      f.e_val = '0;
      f.h_val = '0;
      if (op == OP_READ) begin
        reads++;
        f.kind  = KIND_READ;
        f.e_val = e_grid[idx];
        f.h_val = h_grid[idx];
      end else begin
        steps++;
        n = effective_nodes();
        h_grid[n] = h_grid[n-1];
        for (int i = 0; i < n; i++) begin
          h_grid[i] = sum_clamped(h_grid[i], scaled_delta(e_grid[i+1], e_grid[i], h_coeff));
          if (i == 0) begin
            e_grid[0] = e_grid[1];
          end else begin
            e_grid[i] = sum_clamped(e_grid[i],
                                    scaled_delta(h_grid[i], h_grid[i-1], e_coeff));
          end
        end
        e_grid[n] = sum_clamped(e_grid[n], scaled_delta(h_grid[n], h_grid[n-1], e_coeff));
        if (source_node <= n) e_grid[source_node] = sum_clamped(e_grid[source_node], smp);
      end
      awaited.push_back(f);
    endfunction

    function void report(string msg);
      errors++;
      $error("%s", msg);
    endfunction

    function void compare(kind_t kind, logic signed [DATA_W-1:0] e_val,
                          logic signed [DATA_W-1:0] h_val);
      node_fields_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected item: result_kind %0d e_value %0d h_value %0d",
                         kind, e_val, h_val));
        return;
      end
      want = awaited.pop_front();
      if (kind != want.kind)
        report($sformatf("result_kind: expected %0d, actual %0d", want.kind, kind));
      if (e_val !== want.e_val)
        report($sformatf("e_value: expected %0d, actual %0d", want.e_val, e_val));
      if (h_val !== want.h_val)
        report($sformatf("h_value: expected %0d, actual %0d", want.h_val, h_val));
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_operation = 1'b0;
  logic [IDX_W-1:0]         in_node_index = '0;
  logic signed [DATA_W-1:0] in_source_sample = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_result_kind;
  logic signed [DATA_W-1:0] out_e_value;
  logic signed [DATA_W-1:0] out_h_value;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  yee_shadow shadow;
  bit        steady = 1'b0;
  bit        hold_req = 1'b0;

  fdtd_1d_field_update dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_node_index    (in_node_index),
    .in_source_sample (in_source_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_e_value      (out_e_value),
    .out_h_value      (out_h_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic send_item(op_t op, logic [IDX_W-1:0] idx, logic signed [DATA_W-1:0] smp);
    int r;
    int gap;
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_node_index    <= idx;
    in_source_sample <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow.accept(op, idx, smp);
    if (!steady) begin
      r = $urandom_range(0, 99);
      if (r < 60) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else if (r < 98) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 60);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (shadow.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(reg_idx_t r, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow.write_reg(r, d);
  endtask

  task automatic load_config(logic [NODES_W-1:0] nodes, logic [SRC_W-1:0] src,
                             logic [ECOEF_W-1:0] ec, logic [HCOEF_W-1:0] hc);
    logic [31:0] noise;
    noise = $urandom();
    write_cfg(REG_ACTIVE_NODES, {noise[31:NODES_W], nodes});
    noise = $urandom();
    write_cfg(REG_SOURCE_NODE, {noise[31:SRC_W], src});
    noise = $urandom();
    write_cfg(REG_E_COEFF, {noise[31:ECOEF_W], ec});
    noise = $urandom();
    write_cfg(REG_H_COEFF, {noise[31:HCOEF_W], hc});
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item(int span);
    int                       r;
    logic signed [DATA_W-1:0] smp;
    logic [IDX_W-1:0]         idx;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      case ($urandom_range(0, 5))
        0: smp = $urandom();
        1: smp = {1'b0, {31{1'b1}}};
        2: smp = {1'b1, 31'b0};
        default: smp = $urandom_range(0, 32'd2097152) - 32'd1048576;
      endcase
      send_item(OP_STEP, IDX_W'($urandom()), smp);
    end else begin
      if (r < 85) idx = IDX_W'($urandom_range(0, (span < 255) ? span + 1 : 255));
      else idx = IDX_W'($urandom());
      send_item(OP_READ, idx, $urandom());
    end
  endtask

  initial begin : result_sink
    int hold_left;
    int quiet_left;
    int r;
    hold_left  = 0;
    quiet_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        shadow.compare(kind_t'(out_result_kind), out_e_value, out_h_value);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 600;
        out_stall <= 1'b1;
      end else if (quiet_left > 0) begin
        quiet_left--;
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          hold_left = $urandom_range(20, 80);
          out_stall <= 1'b1;
        end else if (r < 12) begin
          quiet_left = $urandom_range(20, 120);
          out_stall <= 1'b0;
        end else begin
          out_stall <= (r < 40);
        end
      end
    end
  end

  initial begin : stimulus
    logic [NODES_W-1:0] nodes;
    logic [SRC_W-1:0]   src;
    int                 span;
    shadow = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: 200 nodes, source at 50
    send_item(OP_READ, 8'd0, 32'sd0);
    send_item(OP_READ, 8'd255, '1);
    send_item(OP_STEP, 8'd0, {1'b0, {31{1'b1}}});
    send_item(OP_READ, 8'd50, '0);
    send_item(OP_READ, 8'd49, '0);
    send_item(OP_READ, 8'd51, '0);
    send_item(OP_STEP, 8'hff, {1'b0, {31{1'b1}}});
    send_item(OP_READ, 8'd50, '0);
    send_item(OP_STEP, 8'h00, {1'b1, 31'b0});
    send_item(OP_STEP, 8'h00, {1'b1, 31'b0});
    send_item(OP_READ, 8'd50, '0);
    send_item(OP_READ, 8'd200, '0);
    send_item(OP_READ, 8'd201, '0);
    send_item(OP_STEP, 8'haa, 32'sd0);
    send_item(OP_READ, 8'd0, '0);
    send_item(OP_READ, 8'd1, '0);
    send_item(OP_READ, 8'd199, '0);
    send_item(OP_STEP, 8'h55, 32'sd65536);
    send_item(OP_READ, 8'haa, 32'h5555_5555);
    send_item(OP_READ, 8'h55, 32'haaaa_aaaa);
    wait_drained();

    for (int ph = 1; ph <= 14; ph++) begin
      case (ph)
        1: load_config(9'd2, 8'd0, ECOEF_RST, HCOEF_RST);
        2: load_config(9'd0, 8'd2, 31'd65536, 16'd32768);
        3: load_config(9'd1, 8'd3, 31'd0, 16'd0);
        4: load_config(9'd16, 8'd16, {31{1'b1}}, {16{1'b1}});
        5: load_config(9'd256, 8'd255, ECOEF_RST, HCOEF_RST);
        6: load_config(9'd511, 8'd128, 31'd1 << 20, 16'd4096);
        7: load_config(9'd257, 8'd255, ECOEF_W'($urandom()), HCOEF_W'($urandom()));
        default: begin
          nodes = NODES_W'($urandom_range(2, 40));
          src   = SRC_W'($urandom_range(0, nodes + 2));
          load_config(nodes, src,
                      ($urandom_range(0, 7) == 0) ? ECOEF_W'($urandom())
                                                  : ECOEF_W'($urandom_range(0, 1 << 20)),
                      HCOEF_W'($urandom()));
        end
      endcase
      span   = shadow.effective_nodes();
      steady = (ph % 4 == 2) || (ph == 3);
      for (int k = 0; k < 75; k++) begin
        if (ph == 3 && k == 10) hold_req = 1'b1;
        if (ph == 9 && k == 35) wait_drained();
        random_item(span);
      end
      wait_drained();
    end

    repeat (40) @(posedge clk);
    $display("run covered %0d step items and %0d read items across %0d register writes",
             shadow.steps, shadow.reads, shadow.reg_writes);
    $display("grid sizes 2 to 256, source on edge, ghost and outside, saturating coefficients");
    if (shadow.errors == 0 && shadow.awaited.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
sv/fdtd_pkg.sv
sv/fdtd_ram.sv
sv/fdtd_regs.sv
sv/fdtd_dp.sv
sv/fdtd_ctrl.sv
sv/fdtd_1d_field_update.sv
bench/tb.sv
